@@ rtl/core/sped_pkg.sv @@
`default_nettype none
package sped_pkg;

    localparam int VoltW = 15;
    localparam int AmpW  = 8;
    localparam int VlimW = 14;

    localparam logic [VlimW-1:0] VOLT_LIMIT_RST    = 14'd9999;
    localparam logic [AmpW-1:0]  CURRENT_LIMIT_RST = 8'd200;
    localparam logic [AmpW-1:0]  AMPS_RST          = 8'd100;

    localparam logic [3:0] CURSOR_LAST  = 4'd14;
    localparam logic [3:0] CURSOR_CH2   = 4'd8;
    localparam logic [4:0] MARKER_NONE  = 5'd16;
    localparam logic [4:0] MARKER_CH2   = 5'd10;

    // configuration register indexes
    typedef enum logic {
        REG_VOLT_LIMIT    = 1'b0,
        REG_CURRENT_LIMIT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // field under the cursor, relative to the first cursor position of a channel
    typedef enum logic [2:0] {
        FLD_SIGN,
        FLD_V1000,
        FLD_V100,
        FLD_V10,
        FLD_I100,
        FLD_I10,
        FLD_I1
    } field_t;

    typedef struct packed {
        logic signed [VoltW-1:0] volts;
        logic        [AmpW-1:0]  amps;
    } chan_t;

    function automatic logic [4:0] marker_of(field_t fld);
        logic [4:0] m;
        case (fld)
            FLD_SIGN:  m = 5'd0;
            FLD_V1000: m = 5'd1;
            FLD_V100:  m = 5'd3;
            FLD_V10:   m = 5'd4;
            FLD_I100:  m = 5'd7;
            FLD_I10:   m = 5'd8;
            FLD_I1:    m = 5'd9;
            default:   m = MARKER_NONE;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/encoder_setpoint_editor.sv @@
// Setpoint editor for a two-channel bipolar supply, one beat per scan tick.
// Input channel (in_valid/in_ready): one beat carries the encoder A/B samples
// and the two active-low enable switches of one tick.
// Output channel (out_valid/out_ready): one beat per input beat, carrying both
// channels' voltage (mV, signed) and current (mA) setpoints, the enables,
// the cursor and the blink-marker digit.
// Config port: cfg_write with cfg_index 0 sets the voltage magnitude limit,
// index 1 the current limit. Write only while no beat is in flight.
// An input beat goes through an input register, then the edit/clamp logic
// into the result register. Throughput is one beat per cycle; the result
// register is the only place a stall backs up, so the input register keeps
// taking beats until it is also full.
// Reset: limits go to 9999 mV and 200 mA, setpoints to 0 mV and 100 mA,
// cursor to 0 and the encoder histories to zero. A stalled receiver holds the
// output beat unchanged; no beat is dropped or repeated.
`default_nettype none
module encoder_setpoint_editor
    import sped_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_write,
    input  wire logic                    cfg_index,
    input  wire logic [VlimW-1:0]        cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    enc1_a,
    input  wire logic                    enc1_b,
    input  wire logic                    enc2_a,
    input  wire logic                    enc2_b,
    input  wire logic                    ch1_switch_n,
    input  wire logic                    ch2_switch_n,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [VoltW-1:0]      ch1_volts,
    output logic        [AmpW-1:0]       ch1_milliamps,
    output logic signed [VoltW-1:0]      ch2_volts,
    output logic        [AmpW-1:0]       ch2_milliamps,
    output logic                         ch1_on,
    output logic                         ch2_on,
    output logic        [3:0]            cursor,
    output logic        [4:0]            marker_pos
);

    function automatic chan_t edit_clamp(chan_t cur, logic sel, field_t fld, step_t dir,
                                         logic [VlimW-1:0] vl, logic [AmpW-1:0] il);
        logic signed [VoltW+1:0] v;
        logic signed [VoltW+1:0] vmag;
        logic signed [VoltW+1:0] vlim;
        logic signed [AmpW+1:0]  a;
        logic signed [AmpW+1:0]  alim;
        logic                    up;
        chan_t                   res;
        v    = (VoltW+2)'(cur.volts);
        vmag = (v < 0) ? -v : v;
        vlim = signed'({3'b000, vl});
        a    = signed'({2'b00, cur.amps});
        alim = signed'({2'b00, il});
        up   = (dir == STEP_UP);
        if (sel && dir != STEP_NONE)
        begin
            case (fld)
                FLD_SIGN:  v = up ? vmag : -vmag;
                FLD_V1000: v = up ? v + 17'sd1000 : v - 17'sd1000;
                FLD_V100:  v = up ? v + 17'sd100  : v - 17'sd100;
                FLD_V10:   v = up ? v + 17'sd10   : v - 17'sd10;
                FLD_I100:  a = up ? a + 10'sd100  : a - 10'sd100;
                FLD_I10:   a = up ? a + 10'sd10   : a - 10'sd10;
                FLD_I1:    a = up ? a + 10'sd1    : a - 10'sd1;
                default:   v = v;
            endcase
        end
        if (v >= vlim)
            v = vlim;
        if (v <= -vlim)
            v = -vlim;
        if (a >= alim)
            a = alim;
        if (a <= 0)
            a = '0;
        res.volts = v[VoltW-1:0];
        res.amps  = a[AmpW-1:0];
        return res;
    endfunction

    // config registers
    logic [VlimW-1:0] volt_limit_reg;
    logic [AmpW-1:0]  current_limit_reg;

    // input register
    logic in_valid_reg;
    logic enc1_a_reg, enc1_b_reg, enc2_a_reg, enc2_b_reg;
    logic sw1_n_reg, sw2_n_reg;

    // editor state
    logic [1:0] enc1_hist_reg, enc2_hist_reg;
    logic [3:0] cursor_reg;
    chan_t      chan1_reg, chan2_reg;

    // result register
    logic        out_valid_reg;
    chan_t       res1_reg, res2_reg;
    logic        on1_reg, on2_reg;
    logic [3:0]  cursor_out_reg;
    logic [4:0]  marker_reg;

    logic        advance;
    logic [1:0]  enc1_hist_next, enc2_hist_next;
    logic [3:0]  cursor_next;
    chan_t       chan1_next, chan2_next;
    logic [4:0]  marker_next;
    step_t       dir1, dir2;
    logic        sel1, sel2;
    field_t      fld1, fld2;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        enc1_hist_next = {enc1_hist_reg[0], enc1_a_reg};
        enc2_hist_next = {enc2_hist_reg[0], enc2_a_reg};
        // step on a falling A edge, B gives direction
        dir1 = (enc1_hist_next == 2'b10) ? (enc1_b_reg ? STEP_UP : STEP_DOWN) : STEP_NONE;
        dir2 = (enc2_hist_next == 2'b10) ? (enc2_b_reg ? STEP_UP : STEP_DOWN) : STEP_NONE;

        case (dir2)
            STEP_UP:   cursor_next = (cursor_reg < CURSOR_LAST) ? cursor_reg + 4'd1 : 4'd0;
            STEP_DOWN: cursor_next = (cursor_reg > 4'd0) ? cursor_reg - 4'd1 : CURSOR_LAST;
            default:   cursor_next = cursor_reg;
        endcase

        sel1 = (cursor_next >= 4'd1) && (cursor_next < CURSOR_CH2);
        sel2 = (cursor_next >= CURSOR_CH2) && (cursor_next <= CURSOR_LAST);
        fld1 = field_t'(3'(cursor_next - 4'd1));
        fld2 = field_t'(3'(cursor_next - CURSOR_CH2));

        if (sel1)
            marker_next = marker_of(fld1);
        else if (sel2)
            marker_next = marker_of(fld2) + MARKER_CH2;
        else
            marker_next = MARKER_NONE;

        chan1_next = edit_clamp(chan1_reg, sel1, fld1, dir1, volt_limit_reg, current_limit_reg);
        chan2_next = edit_clamp(chan2_reg, sel2, fld2, dir1, volt_limit_reg, current_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_limit_reg    <= VOLT_LIMIT_RST;
            current_limit_reg <= CURRENT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_VOLT_LIMIT:    volt_limit_reg    <= cfg_data;
                REG_CURRENT_LIMIT: current_limit_reg <= cfg_data[AmpW-1:0];
                default:           volt_limit_reg    <= volt_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enc1_hist_reg <= '0;
            enc2_hist_reg <= '0;
            cursor_reg    <= '0;
            chan1_reg     <= '{volts: '0, amps: AMPS_RST};
            chan2_reg     <= '{volts: '0, amps: AMPS_RST};
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                enc1_hist_reg <= enc1_hist_next;
                enc2_hist_reg <= enc2_hist_next;
                cursor_reg    <= cursor_next;
                chan1_reg     <= chan1_next;
                chan2_reg     <= chan2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            enc1_a_reg <= enc1_a;
            enc1_b_reg <= enc1_b;
            enc2_a_reg <= enc2_a;
            enc2_b_reg <= enc2_b;
            sw1_n_reg  <= ch1_switch_n;
            sw2_n_reg  <= ch2_switch_n;
        end
        if (advance)
        begin
            res1_reg       <= chan1_next;
            res2_reg       <= chan2_next;
            on1_reg        <= !sw1_n_reg;
            on2_reg        <= !sw2_n_reg;
            cursor_out_reg <= cursor_next;
            marker_reg     <= marker_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ch1_volts     = res1_reg.volts;
    assign ch1_milliamps = res1_reg.amps;
    assign ch2_volts     = res2_reg.volts;
    assign ch2_milliamps = res2_reg.amps;
    assign ch1_on        = on1_reg;
    assign ch2_on        = on2_reg;
    assign cursor        = cursor_out_reg;
    assign marker_pos    = marker_reg;

endmodule
`default_nettype wire

@@ rtl/core/sped_checker.sv @@
`default_nettype none
module sped_checker
    import sped_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic signed [VoltW-1:0] ch1_volts,
    input wire logic signed [VoltW-1:0] ch2_volts,
    input wire logic [AmpW-1:0]      ch1_milliamps,
    input wire logic [AmpW-1:0]      ch2_milliamps,
    input wire logic [3:0]           cursor,
    input wire logic [4:0]           marker_pos
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor) && $stable(marker_pos)
            && $stable(ch1_volts) && $stable(ch2_volts)
            && $stable(ch1_milliamps) && $stable(ch2_milliamps))
        else $error("output beat changed while stalled");

    a_cursor_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor <= CURSOR_LAST && ((cursor == 4'd0) == (marker_pos == MARKER_NONE)))
        else $error("cursor out of range or marker disagrees with idle cursor");

    a_marker_ch1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cursor >= 4'd1 && cursor < CURSOR_CH2 |-> marker_pos < MARKER_CH2)
        else $error("channel 1 field marked on second display");

    a_marker_ch2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cursor >= CURSOR_CH2 |-> marker_pos >= MARKER_CH2 && marker_pos <= 5'd19)
        else $error("channel 2 field marked off second display");

endmodule

bind encoder_setpoint_editor sped_checker u_sped_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ch1_volts     (ch1_volts),
    .ch2_volts     (ch2_volts),
    .ch1_milliamps (ch1_milliamps),
    .ch2_milliamps (ch2_milliamps),
    .cursor        (cursor),
    .marker_pos    (marker_pos)
);
`default_nettype wire

@@ tb/tb_encoder_setpoint_editor.sv @@
`default_nettype none
module tb_encoder_setpoint_editor;
    import sped_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int SIGN1_POS    = 1;
    localparam int V1000_POS    = 2;
    localparam int I100_POS     = 5;

    // blink digit of each field within one channel's display
    localparam logic [4:0] FIELD_MARK [7] = '{5'd0, 5'd1, 5'd3, 5'd4, 5'd7, 5'd8, 5'd9};

    typedef struct packed {
        logic enc1_a;
        logic enc1_b;
        logic enc2_a;
        logic enc2_b;
        logic ch1_switch_n;
        logic ch2_switch_n;
    } tick_t;

    typedef struct packed {
        logic signed [VoltW-1:0] ch1_volts;
        logic        [AmpW-1:0]  ch1_milliamps;
        logic signed [VoltW-1:0] ch2_volts;
        logic        [AmpW-1:0]  ch2_milliamps;
        logic                    ch1_on;
        logic                    ch2_on;
        logic        [3:0]       cursor;
        logic        [4:0]       marker_pos;
    } panel_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic                    cfg_index;
    logic [VlimW-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    enc1_a;
    logic                    enc1_b;
    logic                    enc2_a;
    logic                    enc2_b;
    logic                    ch1_switch_n;
    logic                    ch2_switch_n;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [VoltW-1:0] ch1_volts;
    logic        [AmpW-1:0]  ch1_milliamps;
    logic signed [VoltW-1:0] ch2_volts;
    logic        [AmpW-1:0]  ch2_milliamps;
    logic                    ch1_on;
    logic                    ch2_on;
    logic        [3:0]       cursor;
    logic        [4:0]       marker_pos;

    encoder_setpoint_editor u_dut (.*);

    // editor state as predicted
    logic [1:0]              edit_hist;
    logic [1:0]              move_hist;
    logic [3:0]              ed_cursor;
    logic signed [VoltW-1:0] ed_volts [2];
    logic        [AmpW-1:0]  ed_amps  [2];
    logic [VlimW-1:0]        lim_volts;
    logic [AmpW-1:0]         lim_amps;

    panel_t pending_panels [$];
    int     mismatches  = 0;
    int     ticks_sent  = 0;
    int     cycle_count = 0;
    bit     feed_gaps    = 1'b1;
    bit     ready_stalls = 1'b1;
    bit     hold_req     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic step_t step_of(input logic [1:0] hist, input logic b);
        if (hist == 2'b10)
            return b ? STEP_UP : STEP_DOWN;
        return STEP_NONE;
    endfunction

    function automatic void reset_editor();
        edit_hist  = 2'b00;
        move_hist  = 2'b00;
        ed_cursor  = 4'd0;
        ed_volts   = '{default: '0};
        ed_amps    = '{default: AMPS_RST};
        lim_volts  = VOLT_LIMIT_RST;
        lim_amps   = CURRENT_LIMIT_RST;
    endfunction

    function automatic void predict_panel(input tick_t t);
        panel_t     r;
        step_t      edit_step;
        step_t      move_step;
        field_t     fld;
        logic [4:0] mark;
        int         ch;
        int         s;
        int         vl;
        int         il;
        int         v [2];
        int         a [2];
        edit_hist = {edit_hist[0], t.enc1_a};
        move_hist = {move_hist[0], t.enc2_a};
        edit_step = step_of(edit_hist, t.enc1_b);
        move_step = step_of(move_hist, t.enc2_b);
        if (move_step == STEP_UP)
            ed_cursor = (ed_cursor < CURSOR_LAST) ? ed_cursor + 4'd1 : 4'd0;
        else if (move_step == STEP_DOWN)
            ed_cursor = (ed_cursor > 4'd0) ? ed_cursor - 4'd1 : CURSOR_LAST;

        ch   = -1;
        fld  = FLD_SIGN;
        mark = MARKER_NONE;
        // cursor 1..7 is channel 1, 8..14 channel 2; low bits give the field
        if (ed_cursor >= 4'd1 && ed_cursor < CURSOR_CH2)
        begin
            ch   = 0;
            fld  = field_t'(ed_cursor[2:0] - 3'd1);
            mark = FIELD_MARK[fld];
        end
        else if (ed_cursor >= CURSOR_CH2 && ed_cursor <= CURSOR_LAST)
        begin
            ch   = 1;
            fld  = field_t'(ed_cursor[2:0]);
            mark = FIELD_MARK[fld] + MARKER_CH2;
        end

        for (int i = 0; i < 2; i++)
        begin
            v[i] = int'(ed_volts[i]);
            a[i] = int'(ed_amps[i]);
        end
        if (ch >= 0 && edit_step != STEP_NONE)
        begin
            s = (edit_step == STEP_UP) ? 1 : -1;
            case (fld)
                FLD_SIGN:  v[ch] = s * ((v[ch] < 0) ? -v[ch] : v[ch]);
                FLD_V1000: v[ch] += s * 1000;
                FLD_V100:  v[ch] += s * 100;
                FLD_V10:   v[ch] += s * 10;
                FLD_I100:  a[ch] += s * 100;
                FLD_I10:   a[ch] += s * 10;
                FLD_I1:    a[ch] += s;
                default:   ;
            endcase
        end

        // clamp runs every tick, so a lowered limit bites on the next one
        vl = int'(lim_volts);
        il = int'(lim_amps);
        for (int i = 0; i < 2; i++)
        begin
            if (v[i] >= vl)
                v[i] = vl;
            if (v[i] <= -vl)
                v[i] = -vl;
            if (a[i] >= il)
                a[i] = il;
            if (a[i] <= 0)
                a[i] = 0;
            ed_volts[i] = VoltW'(v[i]);
            ed_amps[i]  = AmpW'(a[i]);
        end

        r.ch1_volts     = ed_volts[0];
        r.ch1_milliamps = ed_amps[0];
        r.ch2_volts     = ed_volts[1];
        r.ch2_milliamps = ed_amps[1];
        r.ch1_on        = ~t.ch1_switch_n;
        r.ch2_on        = ~t.ch2_switch_n;
        r.cursor        = ed_cursor;
        r.marker_pos    = mark;
        pending_panels.push_back(r);
    endfunction

    task automatic send_tick(input tick_t t);
        if (feed_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        enc1_a       <= t.enc1_a;
        enc1_b       <= t.enc1_b;
        enc2_a       <= t.enc2_a;
        enc2_b       <= t.enc2_b;
        ch1_switch_n <= t.ch1_switch_n;
        ch2_switch_n <= t.ch2_switch_n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_panel(t);
        ticks_sent++;
    endtask

    // random switches and B lines, both A lines low
    function automatic tick_t quiet_tick();
        tick_t      t;
        logic [5:0] bits;
        bits     = 6'($urandom_range(0, 63));
        t        = bits;
        t.enc1_a = 1'b0;
        t.enc2_a = 1'b0;
        return t;
    endfunction

    // one detent: A high, then A falls with B giving the direction
    task automatic click(input bit on_cursor, input bit up);
        tick_t t;
        t = quiet_tick();
        if (on_cursor)
            t.enc2_a = 1'b1;
        else
            t.enc1_a = 1'b1;
        send_tick(t);
        t = quiet_tick();
        if (on_cursor)
            t.enc2_b = up;
        else
            t.enc1_b = up;
        send_tick(t);
    endtask

    task automatic move_cursor_to(input int pos);
        while (int'(ed_cursor) != pos)
            click(1'b1, ((pos - int'(ed_cursor) + 15) % 15) <= 7);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_panels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [VlimW-1:0] vl, input logic [AmpW-1:0] il);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_VOLT_LIMIT;
        cfg_data  <= vl;
        @(posedge clk);
        lim_volts = vl;
        cfg_index <= REG_CURRENT_LIMIT;
        cfg_data  <= VlimW'(il);
        @(posedge clk);
        lim_amps = il;
        cfg_write <= 1'b0;
    endtask

    task automatic test_reset_values();
        tick_t t;
        t = '0;
        send_tick(t);
        t.ch1_switch_n = 1'b1;
        t.ch2_switch_n = 1'b1;
        send_tick(t);
    endtask

    task automatic test_cursor_wrap();
        click(1'b1, 1'b0);
        click(1'b1, 1'b1);
    endtask

    task automatic test_sign_edit();
        move_cursor_to(SIGN1_POS);
        click(1'b0, 1'b0);          // zero keeps its sign
        move_cursor_to(V1000_POS);
        click(1'b0, 1'b1);
        move_cursor_to(SIGN1_POS);
        click(1'b0, 1'b0);
        click(1'b0, 1'b1);
    endtask

    task automatic test_zero_limits();
        set_limits('0, '0);
        click(1'b0, 1'b1);
        move_cursor_to(I100_POS);
        click(1'b0, 1'b1);
    endtask

    // sweep the cursor and edit in same-direction runs so setpoints hit the clamps
    task automatic run_gestures(input int n);
        int  start;
        int  pick;
        bit  up;
        tick_t t;
        logic [5:0] bits;
        start = ticks_sent;
        while (ticks_sent - start < n)
        begin
            pick = $urandom_range(0, 9);
            up   = $urandom_range(0, 1);
            if (pick < 3)
            begin
                repeat ($urandom_range(1, 3)) click(1'b1, up);
            end
            else if (pick < 8)
            begin
                repeat ($urandom_range(1, 12)) click(1'b0, up);
            end
            else if (pick == 8)
            begin
                bits = 6'($urandom_range(0, 63));
                t    = bits;
                send_tick(t);
            end
            else
            begin
                send_tick(quiet_tick());
            end
        end
    endtask

    task automatic test_backpressure();
        feed_gaps = 1'b0;
        hold_req  = 1'b1;
        repeat (20) click($urandom_range(0, 1), $urandom_range(0, 1));
        feed_gaps = 1'b1;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        panel_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_panels.size() == 0)
            begin
                $error("output beat with no panel update pending");
                mismatches++;
            end
            else
            begin
                e = pending_panels.pop_front();
                check_field("ch1_volts", e.ch1_volts, ch1_volts);
                check_field("ch1_milliamps", e.ch1_milliamps, ch1_milliamps);
                check_field("ch2_volts", e.ch2_volts, ch2_volts);
                check_field("ch2_milliamps", e.ch2_milliamps, ch2_milliamps);
                check_field("ch1_on", e.ch1_on, ch1_on);
                check_field("ch2_on", e.ch2_on, ch2_on);
                check_field("cursor", e.cursor, cursor);
                check_field("marker_pos", e.marker_pos, marker_pos);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (ready_stalls && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        reset_editor();
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_VOLT_LIMIT;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        enc1_a       <= 1'b0;
        enc1_b       <= 1'b0;
        enc2_a       <= 1'b0;
        enc2_b       <= 1'b0;
        ch1_switch_n <= 1'b1;
        ch2_switch_n <= 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_cursor_wrap();
        test_sign_edit();
        test_zero_limits();

        set_limits(VOLT_LIMIT_RST, CURRENT_LIMIT_RST);
        run_gestures(250);
        set_limits({VlimW{1'b1}}, {AmpW{1'b1}});
        run_gestures(250);
        test_backpressure();
        set_limits(VlimW'($urandom_range(0, 2000)), AmpW'($urandom_range(0, 40)));
        run_gestures(250);
        set_limits(VlimW'($urandom_range(0, 16383)), AmpW'($urandom_range(0, 255)));
        run_gestures(250);
        set_limits(VlimW'($urandom_range(0, 16383)), AmpW'($urandom_range(0, 255)));
        run_gestures(250);

        // closing stretch runs flat out on both sides
        feed_gaps    = 1'b0;
        ready_stalls = 1'b0;
        set_limits(VOLT_LIMIT_RST, CURRENT_LIMIT_RST);
        run_gestures(250);
        drain();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending_panels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
